// ----- rtl/rgb_ratio_pixel_effect_defines.svh -----
// Assertion macros used by the checker file.
`ifndef RGB_RATIO_PIXEL_EFFECT_DEFINES_SVH
`define RGB_RATIO_PIXEL_EFFECT_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define RRPE_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define RRPE_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/rrpe_pkg.sv -----
// Package: widths, modes and register indexes of the ratio recolor block.
`default_nettype none
package rrpe_pkg;
    localparam int CompW  = 8;
    localparam int ParamW = 9;
    localparam int ModeW  = 4;
    localparam int IdxW   = 2;
    localparam int ValW   = 10;   // component + param, signed
    localparam int NumW   = 20;   // numerator / denominator, signed
    localparam int QuoW   = 21;
    localparam int DivStages = 21;

    localparam logic [IdxW-1:0] RegRed   = 2'd0;
    localparam logic [IdxW-1:0] RegGreen = 2'd1;
    localparam logic [IdxW-1:0] RegBlue  = 2'd2;
    localparam logic [IdxW-1:0] RegMode  = 2'd3;

    localparam logic [ModeW-1:0] ModeLast = 4'd12;

    typedef struct packed {
        logic [CompW-1:0] red_in;
        logic [CompW-1:0] green_in;
        logic [CompW-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CompW-1:0] red_out;
        logic [CompW-1:0] green_out;
        logic [CompW-1:0] blue_out;
        logic             div_zero;
    } pixel_out_t;
endpackage
`default_nettype wire

// ----- rtl/rrpe_if.sv -----
// Valid/ready stream interfaces for the pixel channels.
`default_nettype none
interface rrpe_in_if;
    logic                valid;
    logic                ready;
    rrpe_pkg::pixel_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rrpe_out_if;
    logic                 valid;
    logic                 ready;
    rrpe_pkg::pixel_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rgb_ratio_pixel_effect.sv -----
// Top level of the cross-channel ratio recolor pipeline.
// Usage:
//  - Input item: one RGB pixel on in_ch (valid/ready); result on out_ch.
//  - Config: cfg_we/cfg_idx/cfg_data writes red/green/blue params and mode;
//    write only while the pipeline is empty.
//  - Stages: product stage, operand select, 21 restoring-divide stages,
//    add stage, multiply stage with clamp in the output path.
//  - Throughput: one item per cycle unless the output stalls; set by the bit-per-stage divider.
//  - The whole pipe advances as one; it stalls only when the output stage
//    holds an item the receiver does not take. Nothing is lost or repeated.
//  - Bypass modes (0, 13..15) still travel the same pipe, so order is kept.
//  - Reset clears valid bits, not the data registers; params and mode reset to 0.
//  - div_zero marks a result where some channel divided by zero (that
//    channel reads 0).
`default_nettype none
module rgb_ratio_pixel_effect (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rrpe_in_if.sink                            in_ch,
    rrpe_out_if.source                         out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [rrpe_pkg::IdxW-1:0]     cfg_idx,
    input  wire logic [rrpe_pkg::ParamW-1:0]   cfg_data
);
    localparam int Lat = rrpe_pkg::DivStages + 4;

    logic signed [rrpe_pkg::ParamW-1:0] rp_reg, gp_reg, bp_reg;
    logic [rrpe_pkg::ModeW-1:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg <= '0; gp_reg <= '0; bp_reg <= '0; mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                rrpe_pkg::RegRed:   rp_reg <= cfg_data;
                rrpe_pkg::RegGreen: gp_reg <= cfg_data;
                rrpe_pkg::RegBlue:  bp_reg <= cfg_data;
                rrpe_pkg::RegMode:  mode_reg <= cfg_data[rrpe_pkg::ModeW-1:0];
                default: ;
            endcase
        end
    end

    // Advance whenever the last stage is empty or being taken.
    logic [Lat-1:0] vld_reg;
    logic advance;
    assign advance = !vld_reg[Lat-1] || out_ch.ready;
    assign in_ch.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else if (advance) vld_reg <= {vld_reg[Lat-2:0], in_ch.valid};
    end

    // Build channel values.
    logic byp, padd;
    logic signed [rrpe_pkg::ValW-1:0] rv, gv, bv;
    assign byp  = (mode_reg == '0) || (mode_reg > rrpe_pkg::ModeLast);
    assign padd = (mode_reg == 4'd1) || (mode_reg == 4'd2) || (mode_reg == 4'd7)
               || (mode_reg == 4'd8);
    assign rv = $signed({2'b00, in_ch.data.red_in})
              + (padd ? rrpe_pkg::ValW'(rp_reg) : rrpe_pkg::ValW'(1));
    assign gv = $signed({2'b00, in_ch.data.green_in})
              + (padd ? rrpe_pkg::ValW'(gp_reg) : rrpe_pkg::ValW'(1));
    assign bv = $signed({2'b00, in_ch.data.blue_in})
              + (padd ? rrpe_pkg::ValW'(bp_reg) : rrpe_pkg::ValW'(1));

    // Bypass flag and raw pixel ride alongside.
    logic                    byp_reg [Lat];
    rrpe_pkg::pixel_in_t     pix_reg [Lat];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byp_reg[0] <= byp;
            pix_reg[0] <= in_ch.data;
            for (int i = 1; i < Lat; i++)
            begin
                byp_reg[i] <= byp_reg[i-1];
                pix_reg[i] <= pix_reg[i-1];
            end
        end
    end

    logic [rrpe_pkg::CompW-1:0] r_res, g_res, b_res;
    logic r_dz, g_dz, b_dz;

    rrpe_channel u_red (.clk, .advance, .mode(mode_reg), .s(rv), .o1(gv),
        .o2(bv), .p(rp_reg), .q1(gp_reg), .q2(bp_reg), .res(r_res), .dz(r_dz));
    rrpe_channel u_green (.clk, .advance, .mode(mode_reg), .s(gv), .o1(rv),
        .o2(bv), .p(gp_reg), .q1(rp_reg), .q2(bp_reg), .res(g_res), .dz(g_dz));
    rrpe_channel u_blue (.clk, .advance, .mode(mode_reg), .s(bv), .o1(rv),
        .o2(gv), .p(bp_reg), .q1(rp_reg), .q2(gp_reg), .res(b_res), .dz(b_dz));

    assign out_ch.valid = vld_reg[Lat-1];
    always_comb
    begin
        if (byp_reg[Lat-1])
            out_ch.data = '{red_out: pix_reg[Lat-1].red_in,
                            green_out: pix_reg[Lat-1].green_in,
                            blue_out: pix_reg[Lat-1].blue_in, div_zero: 1'b0};
        else
            out_ch.data = '{red_out: r_res, green_out: g_res, blue_out: b_res,
                            div_zero: r_dz | g_dz | b_dz};
    end
endmodule
`default_nettype wire

// ----- rtl/rrpe_channel.sv -----
// One color channel: operand build, pipelined restoring divide, post math, clamp.
`default_nettype none
module rrpe_channel (
    input  wire logic                                clk,
    input  wire logic                                advance,
    input  wire logic [rrpe_pkg::ModeW-1:0]          mode,
    input  wire logic signed [rrpe_pkg::ValW-1:0]    s,
    input  wire logic signed [rrpe_pkg::ValW-1:0]    o1,
    input  wire logic signed [rrpe_pkg::ValW-1:0]    o2,
    input  wire logic signed [rrpe_pkg::ParamW-1:0]  p,
    input  wire logic signed [rrpe_pkg::ParamW-1:0]  q1,
    input  wire logic signed [rrpe_pkg::ParamW-1:0]  q2,
    output logic [rrpe_pkg::CompW-1:0]               res,
    output logic                                     dz
);
    localparam int NW = rrpe_pkg::NumW;
    localparam int QW = rrpe_pkg::QuoW;
    localparam int NS = rrpe_pkg::DivStages;

    typedef struct packed {
        logic signed [NW-1:0] post;
        logic signed [rrpe_pkg::ParamW-1:0] mul;
        logic signed [rrpe_pkg::ParamW-1:0] pre;
        logic neg;
        logic dz;
    } side_t;

    // Stage 1: products
    logic signed [NW-1:0] sp_reg, o1q_reg, o2q_reg, sum_reg, s_reg, o1_reg, o2_reg;
    logic [rrpe_pkg::ModeW-1:0] m1_reg;
    logic signed [rrpe_pkg::ParamW-1:0] p1_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sp_reg  <= NW'(s) * NW'(p);
            o1q_reg <= NW'(o1) * NW'(q1);
            o2q_reg <= NW'(o2) * NW'(q2);
            sum_reg <= NW'(o1) + NW'(o2);
            s_reg   <= NW'(s);
            o1_reg  <= NW'(o1);
            o2_reg  <= NW'(o2);
            m1_reg  <= mode;
            p1_reg  <= p;
        end
    end

    // Stage 2: select operands, take magnitudes
    logic signed [NW-1:0] num_c, den_c, post_c;
    logic signed [rrpe_pkg::ParamW-1:0] mul_c, pre_c;
    always_comb
    begin
        num_c = s_reg; den_c = sum_reg; post_c = '0;
        mul_c = rrpe_pkg::ParamW'(1); pre_c = '0;
        unique case (m1_reg)
            4'd1:  begin num_c = s_reg;   den_c = sum_reg; end
            4'd2:  begin num_c = sum_reg; den_c = s_reg; end
            4'd3:  begin num_c = s_reg;   den_c = sum_reg; post_c = NW'(p1_reg); end
            4'd4:  begin num_c = o1q_reg + o2q_reg; den_c = s_reg; end
            4'd5:  begin num_c = o1q_reg + o2q_reg; den_c = sp_reg; end
            4'd6:  begin num_c = sp_reg; den_c = o1q_reg; post_c = o2q_reg; end
            4'd7:  begin num_c = s_reg;   den_c = sum_reg; mul_c = p1_reg; end
            4'd8:  begin num_c = sum_reg; den_c = s_reg; mul_c = p1_reg; end
            4'd9:  begin num_c = sum_reg; den_c = s_reg; mul_c = p1_reg; pre_c = p1_reg; end
            4'd10: begin num_c = o1q_reg + o2q_reg; den_c = s_reg; mul_c = p1_reg; end
            4'd11: begin num_c = o1q_reg + o2q_reg; den_c = sp_reg; mul_c = p1_reg; end
            default: begin num_c = sp_reg; den_c = o1q_reg; post_c = o2q_reg;
                           mul_c = p1_reg; end
        endcase
    end

    logic [QW-1:0] rem_reg [NS+1];
    logic [QW-1:0] quo_reg [NS+1];
    logic [QW-1:0] dv_reg  [NS+1];
    side_t         sd_reg  [NS+1];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0] <= '0;
            quo_reg[0] <= num_c[NW-1] ? QW'(-num_c) : QW'(num_c);
            dv_reg[0]  <= den_c[NW-1] ? QW'(-den_c) : QW'(den_c);
            sd_reg[0]  <= '{post: post_c, mul: mul_c, pre: pre_c,
                            neg: num_c[NW-1] ^ den_c[NW-1], dz: (den_c == '0)};
        end
    end

    // Stages 3..: one quotient bit per stage
    for (genvar i = 0; i < NS; i++) begin : g_div
        logic [QW:0] tr;
        logic [QW:0] df;
        assign tr = {rem_reg[i], quo_reg[i][QW-1]};
        assign df = tr - {1'b0, dv_reg[i]};
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[i+1] <= df[QW] ? tr[QW-1:0] : df[QW-1:0];
                quo_reg[i+1] <= {quo_reg[i][QW-2:0], ~df[QW]};
                dv_reg[i+1]  <= dv_reg[i];
                sd_reg[i+1]  <= sd_reg[i];
            end
        end
    end

    // Add stage
    logic signed [NW+1:0] sum2_reg;
    side_t sf_reg;
    logic signed [NW+1:0] q_s;
    assign q_s = sd_reg[NS].neg ? -(NW+2)'(quo_reg[NS]) : (NW+2)'(quo_reg[NS]);
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum2_reg <= q_s + (NW+2)'(sd_reg[NS].post) + (NW+2)'(sd_reg[NS].pre);
            sf_reg   <= sd_reg[NS];
        end
    end

    // Multiply stage
    logic signed [NW+11:0] prod_reg;
    logic dzf_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= (NW+12)'(sum2_reg) * (NW+12)'(sf_reg.mul);
            dzf_reg  <= sf_reg.dz;
        end
    end

    always_comb
    begin
        dz = dzf_reg;
        if (dzf_reg || prod_reg < 0) res = '0;
        else if (prod_reg > (NW+12)'(255)) res = 8'hFF;
        else res = prod_reg[rrpe_pkg::CompW-1:0];
    end
endmodule
`default_nettype wire

// ----- rtl/rrpe_checker.sv -----
// Port-level checker for the ratio recolor block, with its bind.
`default_nettype none
`include "rgb_ratio_pixel_effect_defines.svh"
module rrpe_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [rrpe_pkg::CompW-1:0] red_out,
    input wire logic div_zero
);
    // Stalled output holds.
    `RRPE_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // Ready whenever the output is free or taken.
    `RRPE_ASSERT_IMPL(a_rdy, clk, rst_n, !out_valid || out_ready, in_ready)
    // Stalled output red channel and div_zero hold.
    `RRPE_ASSERT_NEXT(a_stall, clk, rst_n, out_valid && !out_ready,
        $stable(red_out) && $stable(div_zero))
endmodule

bind rgb_ratio_pixel_effect rrpe_checker u_rrpe_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .red_out(out_ch.data.red_out), .div_zero(out_ch.data.div_zero));
`default_nettype wire
